@@ design/rpkd_pkg.sv @@
// Shared types, widths, codes and helpers of the particle kick/drift block.
package rpkd_pkg;

   localparam int unsigned WordW  = 32;
   localparam int unsigned MassW  = 31;
   localparam int unsigned StepW  = 31;
   localparam int unsigned MultW  = 8;
   localparam int unsigned HW     = StepW + MultW;  // widest kick step
   localparam int unsigned DivW   = MassW + 1;      // divisor 2*mass
   localparam int unsigned QW     = 41;             // quotient bits kept
   localparam int unsigned SumW   = 50;             // signed add headroom
   localparam int unsigned SqW    = 64;

   // Kick magnitude cap 2^40
   localparam logic [QW-1:0] DvCap = {1'b1, {(QW-1){1'b0}}};

   // Item operation codes
   typedef enum logic [1:0] {
      OP_KICK_DRIFT = 2'd0,
      OP_KICK_FAST  = 2'd1,
      OP_KICK_SLOW  = 2'd2,
      OP_NOP        = 2'd3
   } opcode_type;

   // Register indexes on the configuration port
   localparam logic CsrTimeStep = 1'b0;
   localparam logic CsrMultistep = 1'b1;

   // One classified particle word as it travels front to back
   typedef struct packed {
      logic                      kick;
      logic                      drift;
      logic                      last;
      logic [HW-1:0]             step;
      logic [DivW-1:0]           divisor;
      logic [2:0][WordW-1:0]     frc;
      logic [2:0][WordW-1:0]     vel;
      logic [2:0][WordW-1:0]     pos;
   } task_type;

   // Queue status seen by front, back and top
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Saturate a signed sum to 32 bits
   function automatic logic [WordW-1:0] sat32(input logic [SumW-1:0] x);
      logic [WordW-1:0] r;
      if (!x[SumW-1] && (|x[SumW-2:WordW-1])) begin
         r = {1'b0, {(WordW-1){1'b1}}};
      end else if (x[SumW-1] && !(&x[SumW-2:WordW-1])) begin
         r = {1'b1, {(WordW-1){1'b0}}};
      end else begin
         r = x[WordW-1:0];
      end
      return r;
   endfunction

   // Magnitude of a signed 32-bit word
   function automatic logic [WordW-1:0] abs32(input logic [WordW-1:0] x);
      return x[WordW-1] ? (~x + 1'b1) : x;
   endfunction

endpackage

@@ design/rpkd_if.sv @@
// Request and response channel interfaces.
interface rpkd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [30:0]        mass;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic signed [31:0] vel_in_x;
   logic signed [31:0] vel_in_y;
   logic signed [31:0] vel_in_z;
   logic signed [31:0] pos_in_x;
   logic signed [31:0] pos_in_y;
   logic signed [31:0] pos_in_z;
   logic               last_particle;

   modport source(output valid, opcode, mass, force_x, force_y, force_z,
                  vel_in_x, vel_in_y, vel_in_z, pos_in_x, pos_in_y, pos_in_z,
                  last_particle, input ready);
   modport sink(input valid, opcode, mass, force_x, force_y, force_z,
                vel_in_x, vel_in_y, vel_in_z, pos_in_x, pos_in_y, pos_in_z,
                last_particle, output ready);
endinterface

interface rpkd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_out_x;
   logic signed [31:0] vel_out_y;
   logic signed [31:0] vel_out_z;
   logic signed [31:0] pos_out_x;
   logic signed [31:0] pos_out_y;
   logic signed [31:0] pos_out_z;
   logic [31:0]        max_displacement;
   logic               sweep_done;

   modport source(output valid, vel_out_x, vel_out_y, vel_out_z, pos_out_x,
                  pos_out_y, pos_out_z, max_displacement, sweep_done,
                  input ready);
   modport sink(input valid, vel_out_x, vel_out_y, vel_out_z, pos_out_x,
                pos_out_y, pos_out_z, max_displacement, sweep_done,
                output ready);
endinterface

@@ design/rpkd_front.sv @@
// Front end: accepts request words, decodes the opcode, forms step and divisor.
module rpkd_front
   import rpkd_pkg::*;
(
   rpkd_req_if.sink          req_ch,
   input  logic [StepW-1:0]  time_step,
   input  logic [MultW-1:0]  multistep,
   input  q_stat_type        q_stat,
   output logic              push,
   output task_type          push_task
);

   logic [HW-1:0]   slow_step;
   logic [MassW-1:0] mass_eff;
   opcode_type      op;

   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full;

   // slow step = time_step * multistep
   assign slow_step = time_step * multistep;
   // zero mass counts as one LSB
   assign mass_eff  = (req_ch.mass == '0) ? MassW'(1) : req_ch.mass;
   assign op        = opcode_type'(req_ch.opcode);

   // classify
   always_comb begin
      push_task.kick    = 1'b1;
      push_task.drift   = 1'b0;
      push_task.step    = {{MultW{1'b0}}, time_step};
      case (op)
         OP_KICK_DRIFT: begin
            push_task.drift = 1'b1;
         end
         OP_KICK_FAST: begin
            push_task.drift = 1'b0;
         end
         OP_KICK_SLOW: begin
            push_task.step  = slow_step;
         end
         default: begin
            push_task.kick  = 1'b0;
         end
      endcase
      push_task.last    = req_ch.last_particle && push_task.drift;
      push_task.divisor = {mass_eff, 1'b0};
      push_task.frc     = {req_ch.force_z, req_ch.force_y, req_ch.force_x};
      push_task.vel     = {req_ch.vel_in_z, req_ch.vel_in_y, req_ch.vel_in_x};
      push_task.pos     = {req_ch.pos_in_z, req_ch.pos_in_y, req_ch.pos_in_x};
   end

endmodule

@@ design/rpkd_queue.sv @@
// Two-entry queue of decoded words between front and back.
module rpkd_queue
   import rpkd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  task_type   push_task,
   input  logic       pop,
   output task_type   head,
   output q_stat_type q_stat
);

   task_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign head         = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

@@ design/rpkd_back.sv @@
// Back end: serial kick divider, drift, sweep maximum, square root, result reg.
module rpkd_back
   import rpkd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [StepW-1:0] time_step,
   input  task_type         head,
   input  q_stat_type       q_stat,
   output logic             pop,
   rpkd_rsp_if.source       rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_KMUL, S_KSUM, S_KDIV, S_KAPP,
      S_DMUL, S_DSQ, S_DACC, S_DMAX, S_SQRT, S_DONE
   } state_type;

   state_type             state_ff;
   task_type              task_ff;
   logic [1:0]            k_ff;
   logic [2:0][WordW-1:0] vel_ff;
   logic [2:0][WordW-1:0] pos_ff;
   logic [63:0]           pl_ff;
   logic [HW-1:0]         ph_ff;
   logic [DivW-1:0]       r_ff;
   logic [QW-1:0]         n_ff;
   logic [QW-1:0]         q_ff;
   logic [5:0]            cnt_ff;
   logic                  cap_ff;
   logic [62:0]           prod_ff;
   logic [SqW-1:0]        sqp_ff;
   logic                  sqbig_ff;
   logic [SqW-1:0]        sq_ff;
   logic                  sqsat_ff;
   logic [SqW-1:0]        max_ff;
   logic [SqW-1:0]        x_ff, res_ff, bit_ff;
   logic                  out_valid_ff;
   logic [2:0][WordW-1:0] vel_out_ff, pos_out_ff;
   logic [WordW-1:0]      disp_ff;
   logic                  done_ff;

   logic [WordW-1:0]      f_k, f_mag, v_k, v_mag;
   logic [70:0]           n_sum;
   logic [DivW:0]         r_sh;
   logic                  q_bit;
   logic [QW-1:0]         dv;
   logic [SumW-1:0]       dv_s, vel_sum, dp_s, pos_sum;
   logic [46:0]           dm;
   logic [SqW:0]          acc;
   logic [SqW-1:0]        sq_fin, max_new, sq_try;
   logic                  out_free;

   // per-component operands
   assign f_k   = task_ff.frc[k_ff];
   assign f_mag = abs32(f_k);
   assign v_k   = vel_ff[k_ff];
   assign v_mag = abs32(v_k);

   // kick datapath
   assign n_sum = {7'b0, pl_ff} + {ph_ff, 32'b0};
   assign r_sh  = {r_ff, n_ff[QW-1]};
   assign q_bit = (r_sh >= {1'b0, task_ff.divisor});
   assign dv    = (cap_ff || (q_ff > DvCap)) ? DvCap : q_ff;
   assign dv_s  = f_k[WordW-1] ? (SumW'(0) - {9'b0, dv}) : {9'b0, dv};
   assign vel_sum = {{(SumW-WordW){v_k[WordW-1]}}, v_k} + dv_s;

   // drift datapath
   assign dm      = prod_ff[62:16];
   assign dp_s    = v_k[WordW-1] ? (SumW'(0) - {3'b0, dm}) : {3'b0, dm};
   assign pos_sum = {{(SumW-WordW){pos_ff[k_ff][WordW-1]}}, pos_ff[k_ff]} + dp_s;
   assign acc     = {1'b0, sq_ff} + {1'b0, sqp_ff};
   assign sq_fin  = sqsat_ff ? {SqW{1'b1}} : sq_ff;
   assign max_new = (sq_fin > max_ff) ? sq_fin : max_ff;
   assign sq_try  = res_ff + bit_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign pop      = (state_ff == S_IDLE) && !q_stat.empty;

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.vel_out_x        = vel_out_ff[0];
   assign rsp_ch.vel_out_y        = vel_out_ff[1];
   assign rsp_ch.vel_out_z        = vel_out_ff[2];
   assign rsp_ch.pos_out_x        = pos_out_ff[0];
   assign rsp_ch.pos_out_y        = pos_out_ff[1];
   assign rsp_ch.pos_out_z        = pos_out_ff[2];
   assign rsp_ch.max_displacement = disp_ff;
   assign rsp_ch.sweep_done       = done_ff;

   // sequencer, datapath registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         max_ff       <= '0;
      end else begin
         if (out_valid_ff && rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_stat.empty) begin
                  task_ff  <= head;
                  vel_ff   <= head.vel;
                  pos_ff   <= head.pos;
                  k_ff     <= 2'd0;
                  sq_ff    <= '0;
                  sqsat_ff <= 1'b0;
                  state_ff <= head.kick ? S_KMUL : S_DONE;
               end
            end
            S_KMUL: begin
               pl_ff    <= task_ff.step[31:0] * f_mag;
               ph_ff    <= task_ff.step[HW-1:32] * f_mag;
               state_ff <= S_KSUM;
            end
            S_KSUM: begin
               // quotient of 2^41 or more is capped outright
               cap_ff   <= ({2'b0, n_sum[70:QW]} >= task_ff.divisor);
               r_ff     <= {2'b0, n_sum[70:QW]};
               n_ff     <= n_sum[QW-1:0];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= S_KDIV;
            end
            S_KDIV: begin
               // one restoring step a cycle
               r_ff   <= q_bit ? DivW'(r_sh - {1'b0, task_ff.divisor})
                               : r_sh[DivW-1:0];
               q_ff   <= {q_ff[QW-2:0], q_bit};
               n_ff   <= {n_ff[QW-2:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(QW - 1)) begin
                  state_ff <= S_KAPP;
               end
            end
            S_KAPP: begin
               vel_ff[k_ff] <= sat32(vel_sum);
               if (k_ff == 2'd2) begin
                  k_ff     <= 2'd0;
                  state_ff <= task_ff.drift ? S_DMUL : S_DONE;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_KMUL;
               end
            end
            S_DMUL: begin
               prod_ff  <= v_mag * time_step;
               state_ff <= S_DSQ;
            end
            S_DSQ: begin
               pos_ff[k_ff] <= sat32(pos_sum);
               sqbig_ff     <= |dm[46:32];
               sqp_ff       <= dm[31:0] * dm[31:0];
               state_ff     <= S_DACC;
            end
            S_DACC: begin
               if (sqbig_ff || acc[SqW]) begin
                  sqsat_ff <= 1'b1;
               end else begin
                  sq_ff <= acc[SqW-1:0];
               end
               if (k_ff == 2'd2) begin
                  state_ff <= S_DMAX;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_DMUL;
               end
            end
            S_DMAX: begin
               if (task_ff.last) begin
                  x_ff     <= max_new;
                  res_ff   <= '0;
                  bit_ff   <= {2'b01, {(SqW-2){1'b0}}};
                  max_ff   <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  max_ff   <= max_new;
                  state_ff <= S_DONE;
               end
            end
            S_SQRT: begin
               // digit-by-digit square root, two bits a step
               if (x_ff >= sq_try) begin
                  x_ff   <= x_ff - sq_try;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  vel_out_ff   <= vel_ff;
                  pos_out_ff   <= pos_ff;
                  disp_ff      <= task_ff.last ? res_ff[WordW-1:0] : '0;
                  done_ff      <= task_ff.last;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/respa_particle_kick_drift.sv @@
// Top level of the RESPA particle kick/drift block: CSRs, front, queue, back.
//
//  channel | dir | handshake          | word
//  req_ch  | in  | valid/ready        | one particle and opcode
//  rsp_ch  | out | valid/ready        | updated particle, sweep result
//  csr     | in  | psel/penable/pready| time_step (0x0), multistep (0x4)
//
// A kick runs each component in turn through the shared serial divider, and a
// kick with drift then drifts each component and updates the sweep maximum;
// the last word of a drift sweep adds a square root of that maximum.
// Reset is synchronous; it clears the queue, sequencer and sweep maximum.
// Two words queue ahead of the back end, and the back end starts the next
// word while a finished result waits in the output register.
module respa_particle_kick_drift
   import rpkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rpkd_req_if.sink    req_ch,
   rpkd_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [StepW-1:0] time_step_ff;
   logic [MultW-1:0] multistep_ff;
   logic             push, pop;
   task_type         push_task, head;
   q_stat_type       q_stat;

   // configuration registers
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CsrMultistep) ? {24'b0, multistep_ff}
                                               : {1'b0, time_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= StepW'(328);
         multistep_ff <= MultW'(1);
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == CsrTimeStep) begin
            time_step_ff <= pwdata[StepW-1:0];
         end else begin
            multistep_ff <= pwdata[MultW-1:0];
         end
      end
   end

   rpkd_front u_front (
      .req_ch    (req_ch),
      .time_step (time_step_ff),
      .multistep (multistep_ff),
      .q_stat    (q_stat),
      .push      (push),
      .push_task (push_task)
   );

   rpkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   rpkd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .time_step (time_step_ff),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   a_disp_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.sweep_done |-> rsp_ch.max_displacement == '0)
      else $error("displacement reported outside sweep end");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");
`endif

endmodule
